[src/rcfd_pkg.sv]
// shared types and constants for the remote-control frame decoder
package rcfd_pkg;

  localparam int FRAME_LEN = 18;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_CH0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_CH1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_CH2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_CH3   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_WHEEL = 3'd5;

  localparam logic [10:0] CENTER_RESET = 11'd1024;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       idle_event;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] stick_0;
    logic signed [11:0] stick_1;
    logic signed [11:0] stick_2;
    logic signed [11:0] stick_3;
    logic signed [15:0] wheel;
    logic [1:0]         switch_left;
    logic [1:0]         switch_right;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_bits;
  } out_item_t;

  typedef struct packed {
    logic [10:0] center_offset;
    logic [10:0] deadband_ch0;
    logic [10:0] deadband_ch1;
    logic [10:0] deadband_ch2;
    logic [10:0] deadband_ch3;
    logic [14:0] deadband_wheel;
  } cfg_regs_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  // store status toward the output stage
  typedef struct packed {
    logic frame_done;
    logic short_drop;
  } store_evt_t;

endpackage

[src/rcfd_frame_store.sv]
// byte buffer and saturating byte counter for one frame
module rcfd_frame_store #(
  parameter int COUNT_LIMIT = 36
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_acc,
  input  rcfd_pkg::in_item_t  item,
  output rcfd_pkg::frame_t    frame,
  output rcfd_pkg::store_evt_t evt
);
  import rcfd_pkg::*;

  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);

  logic [FRAME_LEN-1:0][7:0] store_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (item_acc) begin
      if (item.idle_event) begin
        count_nxt = '0;
      end else if (count_r < CNT_W'(COUNT_LIMIT)) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // bytes past the frame length are counted but not kept
  always_ff @(posedge clk) begin
    if (item_acc && !item.idle_event && count_r < CNT_W'(FRAME_LEN)) begin
      store_r[count_r[IDX_W-1:0]] <= item.byte_value;
    end
  end

  assign frame          = store_r;
  assign evt.frame_done = item_acc && item.idle_event && count_r == CNT_W'(FRAME_LEN);
  assign evt.short_drop = item_acc && item.idle_event && count_r != CNT_W'(FRAME_LEN);

endmodule

[src/rcfd_decode.sv]
// field extraction, centering and deadband of a complete frame
module rcfd_decode (
  input  rcfd_pkg::frame_t    frame,
  input  rcfd_pkg::cfg_regs_t cfg,
  output rcfd_pkg::out_item_t res
);
  import rcfd_pkg::*;

  function automatic logic signed [11:0] stick_db(input logic [10:0] raw,
                                                  input logic [10:0] ctr,
                                                  input logic [10:0] band);
    logic signed [11:0] v;
    logic [11:0]        mag;
    v   = $signed({1'b0, raw}) - $signed({1'b0, ctr});
    mag = v[11] ? 12'(-v) : 12'(v);
    return (mag < {1'b0, band}) ? 12'sd0 : v;
  endfunction

  logic [10:0] raw0, raw1, raw2, raw3;
  logic [15:0] wheel_c;
  logic [15:0] wheel_mag;

  assign raw0 = {frame[1][2:0], frame[0]};
  assign raw1 = {frame[2][5:0], frame[1][7:3]};
  assign raw2 = {frame[4][0], frame[3], frame[2][7:6]};
  assign raw3 = {frame[5][3:0], frame[4][7:1]};

  // wraps at 16 bits; the most negative value keeps magnitude 32768
  assign wheel_c   = {frame[17], frame[16]} - {5'd0, cfg.center_offset};
  assign wheel_mag = wheel_c[15] ? (~wheel_c + 16'd1) : wheel_c;

  always_comb begin
    res.stick_0       = stick_db(raw0, cfg.center_offset, cfg.deadband_ch0);
    res.stick_1       = stick_db(raw1, cfg.center_offset, cfg.deadband_ch1);
    res.stick_2       = stick_db(raw2, cfg.center_offset, cfg.deadband_ch2);
    res.stick_3       = stick_db(raw3, cfg.center_offset, cfg.deadband_ch3);
    res.wheel         = (wheel_mag < {1'b0, cfg.deadband_wheel}) ? 16'sd0 : $signed(wheel_c);
    res.switch_left   = frame[5][7:6];
    res.switch_right  = frame[5][5:4];
    res.mouse_x       = $signed({frame[7], frame[6]});
    res.mouse_y       = $signed({frame[9], frame[8]});
    res.mouse_z       = $signed({frame[11], frame[10]});
    res.mouse_buttons = {frame[13], frame[12]};
    res.key_bits      = {frame[15], frame[14]};
  end

endmodule

[src/rcfd_out_buf.sv]
// result register with a skid entry so input keeps flowing under stall
module rcfd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  rcfd_pkg::out_item_t res,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output rcfd_pkg::out_item_t out_data
);
  import rcfd_pkg::*;

  logic      out_valid_r, skid_valid_r;
  out_item_t out_data_r, skid_data_r;
  logic      hold;

  assign hold = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (hold) begin
      if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= res_valid;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hold) begin
      if (res_valid) begin
        skid_data_r <= res;
      end
    end else if (skid_valid_r) begin
      out_data_r  <= skid_data_r;
      skid_data_r <= res;
    end else begin
      out_data_r <= res;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/rc_frame_decoder_deadband.sv]
// top level of the remote-control frame decoder with per-channel deadband
//
// Takes one received byte or one idle-line event per transaction, every cycle
// while in_stall is low. Bytes are kept in an 18-byte frame buffer and counted
// (the count saturates at COUNT_LIMIT). An idle event after exactly 18 bytes
// yields one decoded result, registered in the result register or the skid
// buffer; any other idle event yields nothing, and every idle event restarts
// the count. A result register plus a one-entry skid buffer sit on the output,
// so input transactions continue while a result waits; in_stall rises only
// when both hold a result. The configuration port is always ready and should
// be written while no frame is being decoded.
module rc_frame_decoder_deadband #(
  parameter int COUNT_LIMIT = 36
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  rcfd_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output rcfd_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import rcfd_pkg::*;

  cfg_regs_t  cfg_r;
  logic       in_acc;
  frame_t     frame;
  store_evt_t evt;
  out_item_t  res;
  logic       buf_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_offset  <= CENTER_RESET;
      cfg_r.deadband_ch0   <= '0;
      cfg_r.deadband_ch1   <= '0;
      cfg_r.deadband_ch2   <= '0;
      cfg_r.deadband_ch3   <= '0;
      cfg_r.deadband_wheel <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_OFFSET:  cfg_r.center_offset  <= cfg_data[10:0];
        REG_DEADBAND_CH0:   cfg_r.deadband_ch0   <= cfg_data[10:0];
        REG_DEADBAND_CH1:   cfg_r.deadband_ch1   <= cfg_data[10:0];
        REG_DEADBAND_CH2:   cfg_r.deadband_ch2   <= cfg_data[10:0];
        REG_DEADBAND_CH3:   cfg_r.deadband_ch3   <= cfg_data[10:0];
        REG_DEADBAND_WHEEL: cfg_r.deadband_wheel <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  rcfd_frame_store #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (in_acc),
    .item     (in_data),
    .frame    (frame),
    .evt      (evt)
  );

  rcfd_decode u_decode (
    .frame (frame),
    .cfg   (cfg_r),
    .res   (res)
  );

  rcfd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (evt.frame_done),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a waiting skid entry implies the result register is occupied
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> out_valid)
    else $error("skid entry held with empty result register");

  // after a completed frame the output always holds a valid result next cycle
  a_frame_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    evt.frame_done |=> out_valid)
    else $error("decoded frame did not reach the output");

  // a wrong-length idle never produces a result by itself
  a_drop_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (evt.short_drop && !out_valid && !buf_full) |=> !out_valid)
    else $error("result appeared for a wrong-length frame");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the remote-control frame decoder with deadband
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rcfd_pkg::*;

  localparam int COUNT_LIMIT   = 36;
  localparam int ITEM_TARGET   = 700;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTS    = 50;
  localparam int N_CFG_SLOTS   = 1 << CFG_IDX_W;

  typedef enum int {
    CFG_MODERATE,
    CFG_ZERO,
    CFG_MAX,
    CFG_RANDOM,
    CFG_NARROW
  } cfg_kind_e;

  typedef struct {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } directed_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // typed expectation travels with the input transaction it belongs to
  logic      row_typed = 1'b0;
  out_item_t row_want  = '0;

  // shadow copy of the decoder state
  cfg_regs_t   shadow_cfg;
  logic [7:0]  shadow_store [FRAME_LEN];
  int          shadow_count;
  out_item_t   pending_frames [$];

  int send_idle_pct    = 0;
  int stall_pct        = 0;
  int items_sent       = 0;
  int frames_predicted = 0;
  int frames_checked   = 0;
  int reg_writes       = 0;
  int mismatch_cnt     = 0;
  int phase_no         = 0;

  rc_frame_decoder_deadband #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[rc_frame_decoder_deadband] ERROR");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    if (mismatch_cnt < MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("frame %0d %s: got %h, expected %h",
                              frames_checked, name, got, want));
  endtask

  function automatic logic signed [11:0] center_stick(logic [10:0] raw, logic [10:0] band);
    int centered;
    centered = int'(raw) - int'(shadow_cfg.center_offset);
    if ((centered < 0 ? -centered : centered) < int'(band)) centered = 0;
    return 12'(centered);
  endfunction

  function automatic out_item_t decode_frame();
    logic [47:0] head;
    logic [15:0] wheel_raw;
    int          wheel_val;
    out_item_t   r;
    head = {shadow_store[5], shadow_store[4], shadow_store[3],
            shadow_store[2], shadow_store[1], shadow_store[0]};
    r.stick_0 = center_stick(head[10:0],  shadow_cfg.deadband_ch0);
    r.stick_1 = center_stick(head[21:11], shadow_cfg.deadband_ch1);
    r.stick_2 = center_stick(head[32:22], shadow_cfg.deadband_ch2);
    r.stick_3 = center_stick(head[43:33], shadow_cfg.deadband_ch3);
    // wheel wraps at 16 bits; -32768 has magnitude 32768 and always survives
    wheel_raw = {shadow_store[17], shadow_store[16]} - {5'd0, shadow_cfg.center_offset};
    wheel_val = int'($signed(wheel_raw));
    if ((wheel_val < 0 ? -wheel_val : wheel_val) < int'(shadow_cfg.deadband_wheel))
      wheel_val = 0;
    r.wheel         = 16'(wheel_val);
    r.switch_left   = head[47:46];
    r.switch_right  = head[45:44];
    r.mouse_x       = {shadow_store[7],  shadow_store[6]};
    r.mouse_y       = {shadow_store[9],  shadow_store[8]};
    r.mouse_z       = {shadow_store[11], shadow_store[10]};
    r.mouse_buttons = {shadow_store[13], shadow_store[12]};
    r.key_bits      = {shadow_store[15], shadow_store[14]};
    return r;
  endfunction

  task automatic absorb_item(in_item_t item, logic typed, out_item_t want);
    if (!item.idle_event) begin
      if (shadow_count < FRAME_LEN) shadow_store[shadow_count] = item.byte_value;
      if (shadow_count < COUNT_LIMIT) shadow_count++;
    end else begin
      if (shadow_count == FRAME_LEN) begin
        pending_frames.push_back(typed ? want : decode_frame());
        frames_predicted++;
      end
      shadow_count = 0;
    end
  endtask

  always @(posedge clk) begin : in_monitor
    if (!rst_n) begin
      shadow_count = 0;
      shadow_cfg   = '{center_offset: CENTER_RESET, default: '0};
    end else if (in_valid && !in_stall) begin
      absorb_item(in_data, row_typed, row_want);
    end
  end

  always @(posedge clk) begin : cfg_monitor
    if (rst_n && cfg_valid && cfg_ready) begin
      reg_writes++;
      case (cfg_index)
        REG_CENTER_OFFSET:  shadow_cfg.center_offset  = cfg_data[10:0];
        REG_DEADBAND_CH0:   shadow_cfg.deadband_ch0   = cfg_data[10:0];
        REG_DEADBAND_CH1:   shadow_cfg.deadband_ch1   = cfg_data[10:0];
        REG_DEADBAND_CH2:   shadow_cfg.deadband_ch2   = cfg_data[10:0];
        REG_DEADBAND_CH3:   shadow_cfg.deadband_ch3   = cfg_data[10:0];
        REG_DEADBAND_WHEEL: shadow_cfg.deadband_wheel = cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : out_monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        flag_mismatch($sformatf("decoded frame with none expected: %h", out_data));
      end else begin
        want = pending_frames.pop_front();
        check_field("stick_0",       16'(out_data.stick_0),       16'(want.stick_0));
        check_field("stick_1",       16'(out_data.stick_1),       16'(want.stick_1));
        check_field("stick_2",       16'(out_data.stick_2),       16'(want.stick_2));
        check_field("stick_3",       16'(out_data.stick_3),       16'(want.stick_3));
        check_field("wheel",         out_data.wheel,              want.wheel);
        check_field("switch_left",   16'(out_data.switch_left),   16'(want.switch_left));
        check_field("switch_right",  16'(out_data.switch_right),  16'(want.switch_right));
        check_field("mouse_x",       out_data.mouse_x,            want.mouse_x);
        check_field("mouse_y",       out_data.mouse_y,            want.mouse_y);
        check_field("mouse_z",       out_data.mouse_z,            want.mouse_z);
        check_field("mouse_buttons", out_data.mouse_buttons,      want.mouse_buttons);
        check_field("key_bits",      out_data.key_bits,           want.key_bits);
        frames_checked++;
      end
    end
  end

  always @(posedge clk) begin : stall_gen
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic drive_item(in_item_t item, logic typed, out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= item;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
    // an idle event that decodes nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(cfg_kind_e kind);
    logic [CFG_DATA_W-1:0] v;
    for (int idx = 0; idx < N_CFG_SLOTS; idx++) begin
      case (kind)
        CFG_ZERO:   v = '0;
        CFG_MAX:    v = '1;
        CFG_RANDOM: v = CFG_DATA_W'($urandom);
        default: begin
          if (CFG_IDX_W'(idx) == REG_DEADBAND_WHEEL) v = CFG_DATA_W'($urandom_range(3000));
          else v = CFG_DATA_W'($urandom_range(kind == CFG_NARROW ? 300 : 40));
          if (CFG_IDX_W'(idx) == REG_CENTER_OFFSET) v = {4'd0, CENTER_RESET};
        end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(idx);
      cfg_data  <= v;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // pushes sticks toward the rails and the deadband edges
  function automatic logic [10:0] pick_stick(logic [10:0] band);
    int c, d;
    c = int'(shadow_cfg.center_offset);
    d = int'(band) + int'($urandom_range(2)) - 1;
    if ($urandom_range(1)) d = -d;
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2, 3: if (c + d >= 0 && c + d <= 2047) return 11'(c + d);
      default: ;
    endcase
    return 11'($urandom);
  endfunction

  task automatic send_random_frame();
    logic [7:0]  bytes [$];
    logic [47:0] head;
    logic [15:0] c, d, whl;
    in_item_t    item;
    int          pick, len;
    pick = $urandom_range(99);
    if (pick < 82) begin
      head = {4'($urandom), pick_stick(shadow_cfg.deadband_ch3),
              pick_stick(shadow_cfg.deadband_ch2), pick_stick(shadow_cfg.deadband_ch1),
              pick_stick(shadow_cfg.deadband_ch0)};
      for (int i = 0; i < 6; i++) bytes.push_back(head[8*i +: 8]);
      for (int i = 6; i < 16; i++)
        case ($urandom_range(7))
          0:       bytes.push_back(8'h00);
          1:       bytes.push_back(8'hFF);
          2:       bytes.push_back(8'h80);
          3:       bytes.push_back(8'h7F);
          default: bytes.push_back(8'($urandom));
        endcase
      c = {5'd0, shadow_cfg.center_offset};
      d = {1'b0, shadow_cfg.deadband_wheel} + 16'($urandom_range(2)) - 16'd1;
      case ($urandom_range(6))
        0:       whl = c + 16'h8000;  // centers to -32768
        1:       whl = c + d;
        2:       whl = c - d;
        3:       whl = '0;
        4:       whl = '1;
        default: whl = 16'($urandom);
      endcase
      bytes.push_back(whl[7:0]);
      bytes.push_back(whl[15:8]);
    end else begin
      if (pick < 88)      len = $urandom_range(FRAME_LEN - 1);
      else if (pick < 94) len = $urandom_range(COUNT_LIMIT + 6, FRAME_LEN + 1);
      else                len = $urandom_range(1) ? FRAME_LEN - 1 : FRAME_LEN + 1;
      repeat (len) bytes.push_back(8'($urandom));
    end
    item.idle_event = 1'b0;
    foreach (bytes[i]) begin
      item.byte_value = bytes[i];
      drive_item(item, 1'b0, '0);
    end
    item.byte_value = 8'($urandom);
    item.idle_event = 1'b1;
    drive_item(item, 1'b0, '0);
  endtask

  initial begin : stimulus
    directed_row_t directed [$];
    directed_row_t row;
    int            phase_start;

    // empty idle, a two-byte frame, then an all-zero frame at reset settings
    row.typed = 1'b0;
    row.want  = '0;
    row.item  = '{byte_value: 8'h5A, idle_event: 1'b1};
    directed.push_back(row);
    row.item = '{byte_value: 8'hFF, idle_event: 1'b0};
    directed.push_back(row);
    row.item = '{byte_value: 8'h00, idle_event: 1'b0};
    directed.push_back(row);
    row.item = '{byte_value: 8'hC3, idle_event: 1'b1};
    directed.push_back(row);
    row.item = '{byte_value: 8'h00, idle_event: 1'b0};
    repeat (FRAME_LEN) directed.push_back(row);
    row.item  = '{byte_value: 8'hFF, idle_event: 1'b1};
    row.typed = 1'b1;
    row.want  = '{stick_0: -12'sd1024, stick_1: -12'sd1024, stick_2: -12'sd1024,
                  stick_3: -12'sd1024, wheel: -16'sd1024, default: '0};
    directed.push_back(row);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) drive_item(directed[i].item, directed[i].typed, directed[i].want);

    while (phase_no < 6 || items_sent < ITEM_TARGET) begin
      if (phase_no > 0) begin
        drain_results();
        program_regs(cfg_kind_e'(phase_no % 5));
      end
      case (phase_no % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 49; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_frame();
      phase_no++;
    end

    drain_results();
    foreach (pending_frames[i])
      flag_mismatch($sformatf("expected frame never arrived: %h", pending_frames[i]));

    $display("covered %0d input transactions in %0d phases, %0d decoded frames checked",
             items_sent, phase_no, frames_checked);
    $display("%0d register writes, %0d mismatches", reg_writes, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("[rc_frame_decoder_deadband] OK");
    end else begin
      $display("[rc_frame_decoder_deadband] ERROR");
    end
    $finish;
  end

endmodule
